// ===== hw/rtl/calendar_clock_counter_macros.svh =====
// Assertion macros for the calendar clock RTL.
`ifndef CALENDAR_CLOCK_COUNTER_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CCLK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CCLK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cclk_pkg.sv =====
// Types, constants and calendar functions for the calendar clock counter.
package cclk_pkg;

    localparam int YEAR_BITS = 12;
    localparam int YEAR_W    = 12;
    localparam int YEAR_MIN  = 2000;
    localparam int YEAR_MAX  = (1 << YEAR_BITS) - 1;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_SET  = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic              req_type;
        logic [3:0]        set_month;
        logic [4:0]        set_day;
        logic [YEAR_W-1:0] set_year;
        logic [4:0]        set_hour;
        logic [5:0]        set_minute;
        logic [5:0]        set_second;
    } req_t;

    typedef struct packed {
        logic [5:0]        cur_second;
        logic [5:0]        cur_minute;
        logic [4:0]        cur_hour;
        logic [4:0]        cur_day;
        logic [3:0]        cur_month;
        logic [YEAR_W-1:0] cur_year;
        logic              day_rolled;
    } res_t;

    typedef struct packed {
        logic [5:0]           second;
        logic [5:0]           minute;
        logic [4:0]           hour;
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
    } time_t;

    // Leap test without a divider: multiples of 100 and 400 are matched
    // against a constant list of candidates, all compared in parallel.
    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        logic mult100;
        logic mult400;
        mult100 = 1'b0;
        mult400 = 1'b0;
        for (int k = 0; k <= YEAR_MAX / 100; k++) begin
            if (y == YEAR_BITS'(k * 100)) begin
                mult100 = 1'b1;
                if ((k % 4) == 0) begin
                    mult400 = 1'b1;
                end
            end
        end
        return (y[1:0] == 2'b00) && (!mult100 || mult400);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m,
                                           input logic [YEAR_BITS-1:0] y);
        logic [3:0] idx;
        idx = (m >= 4'd1 && m <= 4'd12) ? m - 4'd1 : 4'd0;
        if (m == 4'd2 && is_leap(y)) begin
            return 5'd29;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage

// ===== hw/rtl/cclk_step.sv =====
// Next-state logic of the calendar clock: one-second tick or validated load.
module cclk_step import cclk_pkg::*; (
    input  time_t cur_time,
    input  req_t  req,
    output time_t next_time,
    output logic  rolled
);

    logic [3:0]           set_month_v;
    logic [YEAR_BITS-1:0] set_year_v;
    logic [4:0]           set_dim;
    logic [4:0]           cur_dim;
    logic                 sec_wrap;
    logic                 min_wrap;
    logic                 hour_wrap;
    logic                 day_wrap;
    logic                 month_wrap;

    // Month and year are settled first so the day is checked against them.
    always_comb begin
        set_month_v = (req.set_month >= 4'd1 && req.set_month <= 4'd12) ?
                      req.set_month : 4'd1;
        if (req.set_year < YEAR_W'(YEAR_MIN)) begin
            set_year_v = YEAR_BITS'(YEAR_MIN);
        end else if ({5'd0, req.set_year} > 17'(YEAR_MAX)) begin
            set_year_v = YEAR_BITS'(YEAR_MAX);
        end else begin
            set_year_v = YEAR_BITS'(req.set_year);
        end
        set_dim = days_in(set_month_v, set_year_v);
    end

    assign cur_dim    = days_in(cur_time.month, cur_time.year);
    assign sec_wrap   = (cur_time.second == 6'd59);
    assign min_wrap   = sec_wrap && (cur_time.minute == 6'd59);
    assign hour_wrap  = min_wrap && (cur_time.hour == 5'd23);
    assign day_wrap   = hour_wrap && (cur_time.day >= cur_dim);
    assign month_wrap = day_wrap && (cur_time.month == 4'd12);

    always_comb begin
        next_time = cur_time;
        rolled    = 1'b0;
        if (req.req_type == REQ_SET) begin
            next_time.month  = set_month_v;
            next_time.year   = set_year_v;
            next_time.day    = (req.set_day >= 5'd1 && req.set_day <= set_dim) ?
                               req.set_day : 5'd1;
            next_time.hour   = (req.set_hour < 5'd24) ? req.set_hour : 5'd0;
            next_time.minute = (req.set_minute < 6'd60) ? req.set_minute : 6'd0;
            next_time.second = (req.set_second < 6'd60) ? req.set_second : 6'd0;
        end else begin
            rolled           = hour_wrap;
            next_time.second = sec_wrap ? 6'd0 : cur_time.second + 6'd1;
            if (sec_wrap) begin
                next_time.minute = min_wrap ? 6'd0 : cur_time.minute + 6'd1;
            end
            if (min_wrap) begin
                next_time.hour = hour_wrap ? 5'd0 : cur_time.hour + 5'd1;
            end
            if (hour_wrap) begin
                next_time.day = day_wrap ? 5'd1 : cur_time.day + 5'd1;
            end
            if (day_wrap) begin
                next_time.month = month_wrap ? 4'd1 : cur_time.month + 4'd1;
            end
            // The year holds at its maximum instead of wrapping.
            if (month_wrap && cur_time.year != YEAR_BITS'(YEAR_MAX)) begin
                next_time.year = cur_time.year + YEAR_BITS'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/calendar_clock_counter.sv =====
// Top level of the calendar clock counter: input stage, clock state and result stage.
//
//   Channel  Ports                       Carries
//   input    s_valid s_ready s_payload   tick or set request (req_t)
//   result   m_valid m_ready m_payload   date, time and day-rollover flag (res_t)
//
// Every request gives one result, registered first in the input stage and
// then in the result stage; a new request can be taken in every cycle while the
// result is not held by m_ready. Reset brings the clock to 00:00:00 on
// 1 January 2000. While a result waits on m_ready, one more request is held
// in the input stage, after which s_ready drops.
`include "calendar_clock_counter_macros.svh"

module calendar_clock_counter import cclk_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_payload,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_payload
);

    logic  in_valid_reg;
    req_t  in_req_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    time_t time_reg;
    time_t time_next;
    logic  rolled;
    logic  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cclk_step u_step (
        .cur_time  (time_reg),
        .req       (in_req_reg),
        .next_time (time_next),
        .rolled    (rolled)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            time_reg.second <= 6'd0;
            time_reg.minute <= 6'd0;
            time_reg.hour   <= 5'd0;
            time_reg.day    <= 5'd1;
            time_reg.month  <= 4'd1;
            time_reg.year   <= YEAR_BITS'(YEAR_MIN);
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                time_reg      <= time_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg <= s_payload;
        end
        if (advance) begin
            out_res_reg.cur_second <= time_next.second;
            out_res_reg.cur_minute <= time_next.minute;
            out_res_reg.cur_hour   <= time_next.hour;
            out_res_reg.cur_day    <= time_next.day;
            out_res_reg.cur_month  <= time_next.month;
            out_res_reg.cur_year   <= YEAR_W'(time_next.year);
            out_res_reg.day_rolled <= rolled;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_res_reg;

    `CCLK_ASSERT_NOW(a_month_range, 1'b1, time_reg.month >= 4'd1 && time_reg.month <= 4'd12, "month out of range")
    `CCLK_ASSERT_NOW(a_day_range, 1'b1, time_reg.day >= 5'd1 && time_reg.day <= 5'd31, "day out of range")
    `CCLK_ASSERT_NOW(a_roll_midnight, out_valid_reg && out_res_reg.day_rolled, out_res_reg.cur_second == 6'd0 && out_res_reg.cur_minute == 6'd0 && out_res_reg.cur_hour == 5'd0, "rollover away from midnight")
    `CCLK_ASSERT_NEXT(a_state_hold, !advance, $stable(time_reg), "clock state moved without a request")

endmodule
